// ===== rtl/som_bmu_pkg.sv =====
// ============================================================================
// som_bmu_pkg
// Shared sizes, codes and controller/datapath interface types for the
// self-organizing-map best matching unit search.
// ============================================================================
package som_bmu_pkg;

    localparam int MAX_NODES  = 256;
    localparam int MAX_LENGTH = 16;
    localparam int VALUE_BITS = 16;

    localparam int NODE_IDX_W  = 8;
    localparam int ELEM_IDX_W  = 4;
    localparam int IN_VALUE_W  = 16;
    localparam int NODE_CNT_W  = 9;
    localparam int VEC_LEN_W   = 5;
    localparam int DIST_BITS   = 36;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 9;

    localparam int NODE_BITS = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int ELEM_BITS = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int ADDR_BITS = (MAX_NODES * MAX_LENGTH > 1) ?
                               $clog2(MAX_NODES * MAX_LENGTH) : 1;
    localparam int DIFF_BITS = VALUE_BITS + 1;
    localparam int SQ_BITS   = 2 * VALUE_BITS;
    localparam int ACC_BITS  = SQ_BITS + ELEM_BITS;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_LENGTH = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DRAIN,
        ST_WAIT_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic start;
        logic issue;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic last_issue;
        logic search_done;
    } t_dp_status;

endpackage

// ===== rtl/som_bmu_ctrl.sv =====
// ============================================================================
// som_bmu_ctrl
// Controller state machine: accepts beats while idle, sequences the node
// walk, waits for the pipeline to drain and hands the winner to the output
// register.
// ============================================================================
module som_bmu_ctrl
    import som_bmu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_cmd,
    input  logic       i_last_element,
    input  logic       i_stall,
    input  t_dp_status i_status,
    output logic       o_stall,
    output logic       o_out_valid,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_accept;
    logic   w_start;
    logic   w_load;

    assign w_accept = i_valid && (r_state == ST_IDLE);
    assign w_start  = w_accept && (i_cmd == CMD_QUERY) && i_last_element;
    assign w_load   = (r_state == ST_WAIT_OUT) && (!r_out_valid || !i_stall);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_start) begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (i_status.last_issue) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_status.search_done) begin
                    n_state = ST_WAIT_OUT;
                end
            end
            ST_WAIT_OUT: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.accept   = w_accept;
        o_cmd.start    = w_start;
        o_cmd.issue    = (r_state == ST_SEARCH);
        o_cmd.load_out = w_load;
        o_stall        = (r_state != ST_IDLE);
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/som_bmu_dp.sv =====
// ============================================================================
// som_bmu_dp
// Datapath: weight store, query buffer, configuration registers, node and
// element counters, a four-stage difference/square/accumulate pipeline,
// the running minimum and the output payload register.
// ============================================================================
module som_bmu_dp
    import som_bmu_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_dp_cmd                     i_cmd_bus,
    input  logic                        i_cmd,
    input  logic [NODE_IDX_W-1:0]       i_node_index,
    input  logic [ELEM_IDX_W-1:0]       i_element_index,
    input  logic signed [IN_VALUE_W-1:0] i_element_value,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    output t_dp_status                  o_status,
    output logic [NODE_IDX_W-1:0]       o_winner_index,
    output logic [DIST_BITS-1:0]        o_winner_distance
);

    logic [VALUE_BITS-1:0] r_wmem [MAX_NODES * MAX_LENGTH];
    logic [VALUE_BITS-1:0] r_qbuf [MAX_LENGTH];

    logic [NODE_CNT_W-1:0] r_node_count;
    logic [VEC_LEN_W-1:0]  r_vector_length;

    logic [NODE_BITS-1:0]  r_node;
    logic [ELEM_BITS-1:0]  r_elem;
    logic [NODE_BITS-1:0]  w_last_node;
    logic [ELEM_BITS-1:0]  w_last_elem;
    logic                  w_elem_end;
    logic                  w_node_end;

    logic [VALUE_BITS-1:0] w_in_value;
    logic [ADDR_BITS-1:0]  w_wr_addr;
    logic [ADDR_BITS-1:0]  w_rd_addr;
    logic                  w_wr_ok;
    logic                  w_q_ok;

    logic                  r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    logic                  r_s1_first, r_s2_first, r_s3_first;
    logic                  r_s1_last, r_s2_last, r_s3_last, r_s4_last;
    logic                  r_s1_final, r_s2_final, r_s3_final, r_s4_final;
    logic [NODE_BITS-1:0]  r_s1_node, r_s2_node, r_s3_node, r_s4_node;

    logic [VALUE_BITS-1:0] r_w_rd;
    logic [VALUE_BITS-1:0] r_q_rd;
    logic [DIFF_BITS-1:0]  w_diff;
    logic [VALUE_BITS-1:0] w_mag;
    logic [VALUE_BITS-1:0] r_mag;
    logic [SQ_BITS-1:0]    r_sq;
    logic [ACC_BITS-1:0]   r_acc;

    logic [ACC_BITS-1:0]   r_best;
    logic [NODE_BITS-1:0]  r_best_idx;
    logic [NODE_IDX_W-1:0] r_win_idx;
    logic [DIST_BITS-1:0]  r_win_dist;

    // Clamp the configuration to the sizes the store actually holds.
    always_comb begin
        if (r_node_count == '0) begin
            w_last_node = '0;
        end else if (32'(r_node_count) > MAX_NODES) begin
            w_last_node = NODE_BITS'(MAX_NODES - 1);
        end else begin
            w_last_node = NODE_BITS'(r_node_count - NODE_CNT_W'(1));
        end
        if (r_vector_length == '0) begin
            w_last_elem = '0;
        end else if (32'(r_vector_length) > MAX_LENGTH) begin
            w_last_elem = ELEM_BITS'(MAX_LENGTH - 1);
        end else begin
            w_last_elem = ELEM_BITS'(r_vector_length - VEC_LEN_W'(1));
        end
    end

    assign w_elem_end = (r_elem == w_last_elem);
    assign w_node_end = (r_node == w_last_node);

    assign o_status.last_issue  = i_cmd_bus.issue && w_elem_end && w_node_end;
    assign o_status.search_done = r_s4_valid && r_s4_last && r_s4_final;

    assign w_in_value = VALUE_BITS'(i_element_value);
    assign w_wr_ok    = (32'(i_node_index) < MAX_NODES) &&
                        (32'(i_element_index) < MAX_LENGTH);
    assign w_q_ok     = (32'(i_element_index) < MAX_LENGTH);
    assign w_wr_addr  = ADDR_BITS'(32'(i_node_index) * MAX_LENGTH +
                                   32'(i_element_index));
    assign w_rd_addr  = ADDR_BITS'(32'(r_node) * MAX_LENGTH + 32'(r_elem));

    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.accept && (i_cmd == CMD_WRITE) && w_wr_ok) begin
            r_wmem[w_wr_addr] <= w_in_value;
        end
        r_w_rd <= r_wmem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.accept && (i_cmd == CMD_QUERY) && w_q_ok) begin
            r_qbuf[ELEM_BITS'(i_element_index)] <= w_in_value;
        end
        r_q_rd <= r_qbuf[r_elem];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count    <= NODE_CNT_W'(256);
            r_vector_length <= VEC_LEN_W'(16);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NODE_COUNT:    r_node_count    <= i_cfg_data[NODE_CNT_W-1:0];
                CFG_VECTOR_LENGTH: r_vector_length <= i_cfg_data[VEC_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node <= '0;
            r_elem <= '0;
        end else if (i_cmd_bus.start) begin
            r_node <= '0;
            r_elem <= '0;
        end else if (i_cmd_bus.issue) begin
            if (w_elem_end) begin
                r_elem <= '0;
                r_node <= r_node + NODE_BITS'(1);
            end else begin
                r_elem <= r_elem + ELEM_BITS'(1);
            end
        end
    end

    assign w_diff = {r_w_rd[VALUE_BITS-1], r_w_rd} - {r_q_rd[VALUE_BITS-1], r_q_rd};
    assign w_mag  = w_diff[DIFF_BITS-1] ? VALUE_BITS'(-w_diff) : VALUE_BITS'(w_diff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd_bus.issue;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid && r_s3_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_first <= (r_elem == '0);
        r_s1_last  <= w_elem_end;
        r_s1_final <= w_node_end;
        r_s1_node  <= r_node;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        r_s2_final <= r_s1_final;
        r_s2_node  <= r_s1_node;
        r_s3_first <= r_s2_first;
        r_s3_last  <= r_s2_last;
        r_s3_final <= r_s2_final;
        r_s3_node  <= r_s2_node;
        r_s4_last  <= r_s3_last;
        r_s4_final <= r_s3_final;
        r_s4_node  <= r_s3_node;
        r_mag      <= w_mag;
        r_sq       <= SQ_BITS'(r_mag) * SQ_BITS'(r_mag);
        if (r_s3_valid) begin
            if (r_s3_first) begin
                r_acc <= ACC_BITS'(r_sq);
            end else begin
                r_acc <= r_acc + ACC_BITS'(r_sq);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s4_valid && ((r_s4_node == '0) || (r_acc < r_best))) begin
            r_best     <= r_acc;
            r_best_idx <= r_s4_node;
        end
        if (i_cmd_bus.load_out) begin
            r_win_idx  <= NODE_IDX_W'(r_best_idx);
            r_win_dist <= DIST_BITS'(r_best);
        end
    end

    assign o_winner_index    = r_win_idx;
    assign o_winner_distance = r_win_dist;

endmodule

// ===== rtl/som_best_matching_unit_search.sv =====
// Flow: the last query beat starts a search over the configured nodes; weight
// writes and other query beats are taken without holding off the input.
// Throughput: one distance term per cycle from one weight store read port and one
// multiplier; a search stalls the input until its result is loaded for output.
// Reset: synchronous, active low; clears control state and sets node_count to
// 256 and vector_length to 16; weight store and query buffer hold no reset.
// ============================================================================
// som_best_matching_unit_search
// Self-organizing-map winner search over a stored weight map.
// ============================================================================
module som_best_matching_unit_search
    import som_bmu_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_cmd,
    input  logic [NODE_IDX_W-1:0]        i_node_index,
    input  logic [ELEM_IDX_W-1:0]        i_element_index,
    input  logic signed [IN_VALUE_W-1:0] i_element_value,
    input  logic                         i_last_element,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [NODE_IDX_W-1:0]        o_winner_index,
    output logic [DIST_BITS-1:0]         o_winner_distance,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    som_bmu_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_cmd          (i_cmd),
        .i_last_element (i_last_element),
        .i_stall        (i_stall),
        .i_status       (w_status),
        .o_stall        (o_stall),
        .o_out_valid    (o_valid),
        .o_cmd          (w_cmd)
    );

    som_bmu_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd_bus         (w_cmd),
        .i_cmd             (i_cmd),
        .i_node_index      (i_node_index),
        .i_element_index   (i_element_index),
        .i_element_value   (i_element_value),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_status          (w_status),
        .o_winner_index    (o_winner_index),
        .o_winner_distance (o_winner_distance)
    );

endmodule

// ===== rtl/som_bmu_checker.sv =====
// ============================================================================
// som_bmu_checker
// Port-level checks on the best matching unit search, bound to the top level.
// ============================================================================
module som_bmu_checker
    import som_bmu_pkg::*;
(
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_stall,
    input logic                         i_cmd,
    input logic                         i_last_element,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic [NODE_IDX_W-1:0]        o_winner_index,
    input logic [DIST_BITS-1:0]         o_winner_distance
);

    // A stalled result beat keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_winner_index) &&
                               $stable(o_winner_distance))
        else $error("stalled result beat changed");

    // A final query beat starts a search that holds off further input.
    a_search_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_cmd == CMD_QUERY) && i_last_element |=> o_stall)
        else $error("search did not stall the input");

    // Writes and ordinary query beats never hold off the next beat.
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !((i_cmd == CMD_QUERY) && i_last_element) |=> !o_stall)
        else $error("input stalled without a search");

    // A new result only appears at the end of a search.
    a_result_from_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result beat without a search");

endmodule

bind som_best_matching_unit_search som_bmu_checker u_som_bmu_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_stall           (o_stall),
    .i_cmd             (i_cmd),
    .i_last_element    (i_last_element),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_winner_index    (o_winner_index),
    .o_winner_distance (o_winner_distance)
);

// ===== test/som_best_matching_unit_search_test.sv =====
`timescale 1ns / 100ps
// ============================================================================
// som_best_matching_unit_search_test
// Self-checking bench for the best matching unit search. It preloads element
// zero of every node, the full vectors of the first few nodes and the query
// buffer, then runs directed beats and random phases. The phases use several
// map sizes, including clamped register values, and three idling mixes. A
// tracker class mirrors the weight map and the registers, predicts each
// winner beat and compares it field by field.
// ============================================================================
module som_best_matching_unit_search_test;
    import som_bmu_pkg::*;

    localparam int HALF_PERIOD     = 5;
    localparam int RESET_CYCLES    = 6;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int SETTLE_CYCLES   = 12;
    localparam int HOLD_CYCLES     = 2000;
    localparam int PHASE_ITEMS     = 18;
    localparam int BIG_PHASE_ITEMS = 15;
    localparam int REPORT_LIMIT    = 10;
    localparam int FULL_NODES      = 8;

    typedef struct packed {
        logic                         cmd;
        logic [NODE_IDX_W-1:0]        node;
        logic [ELEM_IDX_W-1:0]        elem;
        logic signed [IN_VALUE_W-1:0] value;
        logic                         last;
    } t_map_beat;

    typedef struct packed {
        logic [NODE_IDX_W-1:0] index;
        logic [DIST_BITS-1:0]  distance;
    } t_winner;

    typedef enum int {
        VAL_FULL,
        VAL_NEAR_ZERO,
        VAL_EXTREME,
        VAL_NEAR_NODE
    } t_value_style;

    class winner_tracker;
        logic signed [IN_VALUE_W-1:0] weights [MAX_NODES*MAX_LENGTH];
        logic signed [IN_VALUE_W-1:0] query [MAX_LENGTH];
        logic [NODE_CNT_W-1:0]        node_count;
        logic [VEC_LEN_W-1:0]         vector_length;
        t_winner                      winners_due [$];
        int                           errors;

        function new();
            node_count    = NODE_CNT_W'(256);
            vector_length = VEC_LEN_W'(16);
            errors        = 0;
        endfunction

        function void flag(string msg);
            if (errors < REPORT_LIMIT) begin
                $display("%s", msg);
            end
            errors++;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] index,
                                   logic [CFG_DATA_W-1:0] data);
            if (index == CFG_NODE_COUNT) begin
                node_count = data[NODE_CNT_W-1:0];
            end else if (index == CFG_VECTOR_LENGTH) begin
                vector_length = data[VEC_LEN_W-1:0];
            end
        endfunction

        function void note_beat(t_map_beat b);
            int              count;
            int              len;
            int              diff;
            int              best;
            longint unsigned sum;
            longint unsigned best_sum;
            t_winner         w;
            if (b.cmd == CMD_WRITE) begin
                weights[int'(b.node) * MAX_LENGTH + int'(b.elem)] = b.value;
                return;
            end
            query[b.elem] = b.value;
            if (!b.last) begin
                return;
            end
            count = (node_count < 1) ? 1 : ((node_count > MAX_NODES) ? MAX_NODES
                                                                     : int'(node_count));
            len = (vector_length < 1) ? 1 : ((vector_length > MAX_LENGTH) ? MAX_LENGTH
                                                                          : int'(vector_length));
            best     = 0;
            best_sum = 0;
            for (int n = 0; n < count; n++) begin
                sum = 0;
                for (int e = 0; e < len; e++) begin
                    diff = int'(weights[n * MAX_LENGTH + e]) - int'(query[e]);
                    sum += longint'(diff) * longint'(diff);
                end
                if (n == 0 || sum < best_sum) begin
                    best_sum = sum;
                    best     = n;
                end
            end
            w.index    = NODE_IDX_W'(best);
            w.distance = DIST_BITS'(best_sum);
            winners_due.push_back(w);
        endfunction

        function void check_winner(logic [NODE_IDX_W-1:0] index,
                                   logic [DIST_BITS-1:0] distance);
            t_winner w;
            if (winners_due.size() == 0) begin
                flag($sformatf("Unexpected winner beat: index %0d distance %0d",
                               index, distance));
                return;
            end
            w = winners_due.pop_front();
            if (index !== w.index || distance !== w.distance) begin
                flag($sformatf("Winner mismatch: expected index %0d distance %0d, got %0d %0d",
                               w.index, w.distance, index, distance));
            end
        endfunction
    endclass

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_stall;
    logic                         i_cmd;
    logic [NODE_IDX_W-1:0]        i_node_index;
    logic [ELEM_IDX_W-1:0]        i_element_index;
    logic signed [IN_VALUE_W-1:0] i_element_value;
    logic                         i_last_element;
    logic                         o_valid;
    logic                         i_stall;
    logic [NODE_IDX_W-1:0]        o_winner_index;
    logic [DIST_BITS-1:0]         o_winner_distance;
    logic                         i_cfg_we;
    logic [CFG_IDX_W-1:0]         i_cfg_index;
    logic [CFG_DATA_W-1:0]        i_cfg_data;

    winner_tracker tracker;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            hold_request  = 0;
    int            hold_left     = 0;
    int            sent_items    = 0;
    int            cycle_count   = 0;
    int            cur_nodes     = MAX_NODES;
    int            cur_len       = MAX_LENGTH;

    som_best_matching_unit_search i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_cmd             (i_cmd),
        .i_node_index      (i_node_index),
        .i_element_index   (i_element_index),
        .i_element_value   (i_element_value),
        .i_last_element    (i_last_element),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_winner_index    (o_winner_index),
        .o_winner_distance (o_winner_distance),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("som_best_matching_unit_search_test: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            tracker.check_winner(o_winner_index, o_winner_distance);
        end
    end

    // The receiver stalls at random, or for a counted stretch when asked.
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    function automatic int clamp(input int value, input int lo, input int hi);
        return (value < lo) ? lo : ((value > hi) ? hi : value);
    endfunction

    function automatic logic signed [IN_VALUE_W-1:0] pick_value(input t_value_style style,
                                                                input int node,
                                                                input int elem);
        case (style)
            VAL_FULL: begin
                return IN_VALUE_W'($urandom);
            end
            VAL_NEAR_ZERO: begin
                return IN_VALUE_W'(int'($urandom_range(4)) - 2);
            end
            VAL_EXTREME: begin
                case ($urandom_range(3))
                    0:       return 16'sh8000;
                    1:       return 16'sh7fff;
                    2:       return 16'sh0000;
                    default: return 16'shffff;
                endcase
            end
            default: begin
                return tracker.weights[node * MAX_LENGTH + elem] +
                       IN_VALUE_W'(int'($urandom_range(2)) - 1);
            end
        endcase
    endfunction

    task automatic send_beat(input t_map_beat b);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid         <= 1'b1;
        i_cmd           <= b.cmd;
        i_node_index    <= b.node;
        i_element_index <= b.elem;
        i_element_value <= b.value;
        i_last_element  <= b.last;
        do @(posedge i_clk); while (o_stall);
        tracker.note_beat(b);
        sent_items++;
    endtask

    task automatic send_write(input int node, input int elem,
                              input logic signed [IN_VALUE_W-1:0] value);
        t_map_beat b;
        b.cmd   = CMD_WRITE;
        b.node  = NODE_IDX_W'(node);
        b.elem  = ELEM_IDX_W'(elem);
        b.value = value;
        b.last  = 1'($urandom_range(1));
        send_beat(b);
    endtask

    task automatic send_query(input int elem, input logic signed [IN_VALUE_W-1:0] value,
                              input logic last);
        t_map_beat b;
        b.cmd   = CMD_QUERY;
        b.node  = NODE_IDX_W'($urandom);
        b.elem  = ELEM_IDX_W'(elem);
        b.value = value;
        b.last  = last;
        send_beat(b);
    endtask

    // A complete vector in shuffled order, sometimes preceded by an element
    // beyond the length in use; only the final beat carries the last mark.
    task automatic send_query_vector(input int len);
        int           order [MAX_LENGTH];
        int           extra;
        int           j;
        int           tmp;
        int           model_node;
        t_value_style style;
        style      = t_value_style'($urandom_range(3));
        model_node = $urandom_range(cur_nodes - 1);
        for (int e = 0; e < len; e++) begin
            order[e] = e;
        end
        for (int e = len - 1; e > 0; e--) begin
            j        = $urandom_range(e);
            tmp      = order[e];
            order[e] = order[j];
            order[j] = tmp;
        end
        if (len < MAX_LENGTH && $urandom_range(3) == 0) begin
            extra = $urandom_range(MAX_LENGTH - 1, len);
            send_query(extra, pick_value(VAL_FULL, 0, 0), 1'b0);
        end
        for (int e = 0; e < len; e++) begin
            send_query(order[e], pick_value(style, model_node, order[e]), e == len - 1);
        end
    endtask

    task automatic pause_sender();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (tracker.winners_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        tracker.set_register(index, data);
    endtask

    task automatic configure(input int nodes, input int len);
        logic [CFG_DATA_W-1:0] data;
        pause_sender();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_register(CFG_NODE_COUNT, CFG_DATA_W'(nodes));
        data                  = CFG_DATA_W'($urandom);
        data[VEC_LEN_W-1:0]   = VEC_LEN_W'(len);
        write_register(CFG_VECTOR_LENGTH, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_nodes = clamp(nodes, 1, MAX_NODES);
        cur_len   = clamp(len, 1, MAX_LENGTH);
    endtask

    task automatic run_phase(input int budget);
        int start;
        int pick;
        int from_node;
        int to_node;
        bit paused;
        start  = sent_items;
        paused = 1'b0;
        while (sent_items - start < budget) begin
            if (!paused && sent_items - start >= budget / 2) begin
                pause_sender();
                paused = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 40) begin
                send_query_vector(cur_len);
            end else if (pick < 50) begin
                send_query($urandom_range(MAX_LENGTH - 1),
                           pick_value(t_value_style'($urandom_range(3)),
                                      $urandom_range(FULL_NODES - 1),
                                      $urandom_range(MAX_LENGTH - 1)),
                           1'($urandom_range(1)));
            end else if (pick < 58) begin
                from_node = $urandom_range(cur_nodes - 1);
                to_node   = $urandom_range(cur_nodes - 1);
                for (int e = 0; e < cur_len; e++) begin
                    send_write(to_node, e, tracker.weights[from_node * MAX_LENGTH + e]);
                end
            end else if (pick < 90) begin
                send_write($urandom_range(cur_nodes - 1), $urandom_range(MAX_LENGTH - 1),
                           pick_value(t_value_style'($urandom_range(2)), 0, 0));
            end else begin
                send_write($urandom_range(MAX_NODES - 1), $urandom_range(MAX_LENGTH - 1),
                           pick_value(t_value_style'($urandom_range(2)), 0, 0));
            end
        end
    endtask

    initial begin
        tracker = new();
        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_cmd           <= CMD_WRITE;
        i_node_index    <= '0;
        i_element_index <= '0;
        i_element_value <= '0;
        i_last_element  <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= '0;
        i_cfg_data      <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Element zero of every node, every element of the first nodes and the
        // whole query buffer are written before the first search. Searches over
        // more than the first nodes use a vector length of one.
        for (int n = 0; n < MAX_NODES; n++) begin
            for (int e = 0; e < ((n < FULL_NODES) ? MAX_LENGTH : 1); e++) begin
                send_write(n, e, pick_value(VAL_FULL, 0, 0));
            end
        end
        for (int e = 0; e < MAX_LENGTH; e++) begin
            send_query(e, pick_value(VAL_FULL, 0, 0), 1'b0);
        end

        send_idle_pct = 27;
        recv_idle_pct = 79;
        configure(FULL_NODES, MAX_LENGTH);
        send_write(0, 0, 16'sh8000);
        send_write(MAX_NODES - 1, MAX_LENGTH - 1, 16'sh7fff);
        send_query(MAX_LENGTH - 1, 16'sh8000, 1'b0);
        send_query(0, 16'sh7fff, 1'b1);
        send_query(3, 16'sh0000, 1'b1);
        configure(1, MAX_LENGTH);
        send_query(7, 16'shffff, 1'b1);
        // Two nodes at distance zero tie, and an element past the length is ignored.
        configure(MAX_NODES, 1);
        send_write(3, 0, 16'sd100);
        send_write(7, 0, 16'sd100);
        send_query(9, -16'sd5, 1'b0);
        send_query(0, 16'sd100, 1'b1);
        configure(0, 0);
        send_query(0, 16'sh7fff, 1'b1);
        configure(511, 1);
        send_query(1, 16'sd1, 1'b0);
        send_query(0, 16'sd1, 1'b1);
        configure(FULL_NODES, 31);
        send_query(1, 16'sd1, 1'b1);

        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    send_idle_pct = 27;
                    recv_idle_pct = 79;
                end
                1: begin
                    send_idle_pct = 79;
                    recv_idle_pct = 27;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int p = 0; p < 5; p++) begin
                if (p == 0) begin
                    case (mode)
                        0:       configure(MAX_NODES, 1);
                        1:       configure(FULL_NODES, 31);
                        default: configure(0, 0);
                    endcase
                end else if (p == 4) begin
                    configure($urandom_range(FULL_NODES, 1), $urandom_range(MAX_LENGTH, 7));
                end else begin
                    configure($urandom_range(FULL_NODES, 1), $urandom_range(6, 1));
                end
                if (mode == 2 && p == 1) begin
                    hold_request = HOLD_CYCLES;
                    repeat (6) send_query_vector(cur_len);
                end
                run_phase((cur_nodes * cur_len > 256) ? BIG_PHASE_ITEMS : PHASE_ITEMS);
            end
        end

        pause_sender();
        repeat (cur_nodes * cur_len + SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.winners_due.size() == 0) begin
            $display("som_best_matching_unit_search_test: PASS");
        end else begin
            $display("som_best_matching_unit_search_test: FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/som_bmu_pkg.sv
rtl/som_bmu_ctrl.sv
rtl/som_bmu_dp.sv
rtl/som_best_matching_unit_search.sv
rtl/som_bmu_checker.sv
test/som_best_matching_unit_search_test.sv
